@@ hw/rtl/vn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_pkg
// Shared types and constants of the vector normalizer.
// ----------------------------------------------------------------------------
package vn_pkg;

    localparam int LanesN    = 4;
    localparam int SqrtSteps = 32;
    localparam int QuotBits  = 31;

    localparam logic [2:0]  DimReset = 3'd3;
    localparam logic [30:0] UnitOne  = 31'h4000_0000;
    localparam logic [32:0] LenMax   = 33'h1_0000_0000;

    typedef logic [31:0] mag_t;

    // data that rides along with each item through the pipeline
    typedef struct packed {
        mag_t [3:0] mag;
        logic [3:0] neg;
        logic [3:0] act;
    } side_t;

endpackage

@@ hw/rtl/vn_sumsq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_sumsq
// Magnitudes, exact squares and 65-bit sum of squares in four stages.
// ----------------------------------------------------------------------------
module vn_sumsq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [31:0]  comp_x,
    input  logic signed [31:0]  comp_y,
    input  logic signed [31:0]  comp_z,
    input  logic signed [31:0]  comp_w,
    input  logic [2:0]          dim,
    output logic                sum_valid,
    output logic [64:0]         sum,
    output vn_pkg::side_t       sum_side
);

    logic [3:0]     valid_reg;
    vn_pkg::side_t  side_a_reg, side_b_reg, side_c_reg, side_d_reg;
    vn_pkg::side_t  side_a_next;
    logic [63:0]    sq_reg [vn_pkg::LanesN];
    logic [64:0]    pair0_reg, pair1_reg;
    logic [64:0]    sum_reg;
    logic [31:0]    comp [vn_pkg::LanesN];

    assign comp[0] = comp_x;
    assign comp[1] = comp_y;
    assign comp[2] = comp_z;
    assign comp[3] = comp_w;

    always_comb
    begin
        side_a_next = '0;
        for (int i = 0; i < vn_pkg::LanesN; i++)
        begin
            side_a_next.neg[i] = comp[i][31];
            side_a_next.mag[i] = comp[i][31] ? (~comp[i] + 32'd1) : comp[i];
        end
        // dimension saturates to 2..4
        unique case (dim)
            3'd0, 3'd1, 3'd2: side_a_next.act = 4'b0011;
            3'd3:             side_a_next.act = 4'b0111;
            default:          side_a_next.act = 4'b1111;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_a_reg <= side_a_next;
            side_b_reg <= side_a_reg;
            side_c_reg <= side_b_reg;
            side_d_reg <= side_c_reg;
            for (int i = 0; i < vn_pkg::LanesN; i++)
            begin
                sq_reg[i] <= side_a_reg.act[i] ?
                             (64'(side_a_reg.mag[i]) * 64'(side_a_reg.mag[i])) : 64'd0;
            end
            pair0_reg <= {1'b0, sq_reg[0]} + {1'b0, sq_reg[1]};
            pair1_reg <= {1'b0, sq_reg[2]} + {1'b0, sq_reg[3]};
            sum_reg   <= pair0_reg + pair1_reg;
        end
    end

    assign sum_valid = valid_reg[3];
    assign sum       = sum_reg;
    assign sum_side  = side_d_reg;

endmodule

@@ hw/rtl/vn_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_isqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vn_isqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                sum_valid,
    input  logic [64:0]         sum,
    input  vn_pkg::side_t       sum_side,
    output logic                len_valid,
    output logic [32:0]         len,
    output vn_pkg::side_t       len_side
);

    localparam int N = vn_pkg::SqrtSteps;

    logic [35:0]   rem_reg  [N];
    logic [31:0]   root_reg [N];
    logic [63:0]   n_reg    [N];
    logic          big_reg  [N];
    vn_pkg::side_t side_reg [N];
    logic [N-1:0]  valid_reg;

    genvar s;
    generate
        for (s = 0; s < N; s++)
        begin : g_step
            logic [35:0]   rem_in, cand, trial;
            logic [31:0]   root_in;
            logic [63:0]   n_in;
            logic          big_in, vld_in, ge;
            vn_pkg::side_t side_in;

            if (s == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign n_in    = sum[63:0];
                assign big_in  = sum[64];   // sum is exactly 2^64
                assign side_in = sum_side;
                assign vld_in  = sum_valid;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[s-1];
                assign root_in = root_reg[s-1];
                assign n_in    = n_reg[s-1];
                assign big_in  = big_reg[s-1];
                assign side_in = side_reg[s-1];
                assign vld_in  = valid_reg[s-1];
            end

            assign cand  = {rem_in[33:0], n_in[63:62]};
            assign trial = {2'b00, root_in, 2'b01};
            assign ge    = cand >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[s] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s]  <= ge ? (cand - trial) : cand;
                    root_reg[s] <= {root_in[30:0], ge};
                    n_reg[s]    <= {n_in[61:0], 2'b00};
                    big_reg[s]  <= big_in;
                    side_reg[s] <= side_in;
                end
            end
        end
    endgenerate

    assign len_valid = valid_reg[N-1];
    assign len       = big_reg[N-1] ? vn_pkg::LenMax : {1'b0, root_reg[N-1]};
    assign len_side  = side_reg[N-1];

endmodule

@@ hw/rtl/vn_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_divider
// Four-lane pipelined restoring divider: (|c| << 30) / len, one bit a stage.
// ----------------------------------------------------------------------------
module vn_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                len_valid,
    input  logic [32:0]         len,
    input  vn_pkg::side_t       len_side,
    output logic                quot_valid,
    output logic [32:0]         quot_len,
    output vn_pkg::side_t       quot_side,
    output logic [30:0]         quot [vn_pkg::LanesN],
    output logic [3:0]          quot_ovf
);

    localparam int N = vn_pkg::QuotBits;
    localparam int L = vn_pkg::LanesN;

    logic [61:0]   rem_reg  [N][L];
    logic [30:0]   q_reg    [N][L];
    logic [3:0]    ovf_reg  [N];
    logic [32:0]   len_reg  [N];
    vn_pkg::side_t side_reg [N];
    logic [N-1:0]  valid_reg;

    genvar s;
    generate
        for (s = 0; s < N; s++)
        begin : g_step
            localparam int K = N - 1 - s;
            logic [61:0]   rem_in [L];
            logic [30:0]   q_in   [L];
            logic [3:0]    ovf_in;
            logic [32:0]   len_in;
            vn_pkg::side_t side_in;
            logic          vld_in;
            logic [63:0]   dsh;

            if (s == 0)
            begin : g_first
                for (genvar i = 0; i < L; i++)
                begin : g_lane
                    assign rem_in[i] = {len_side.mag[i], 30'd0};
                    assign q_in[i]   = '0;
                    // quotient of 2^31 or more
                    assign ovf_in[i] = {2'b00, len_side.mag[i]} >= {len, 1'b0};
                end
                assign len_in  = len;
                assign side_in = len_side;
                assign vld_in  = len_valid;
            end
            else
            begin : g_rest
                for (genvar i = 0; i < L; i++)
                begin : g_lane
                    assign rem_in[i] = rem_reg[s-1][i];
                    assign q_in[i]   = q_reg[s-1][i];
                end
                assign ovf_in  = ovf_reg[s-1];
                assign len_in  = len_reg[s-1];
                assign side_in = side_reg[s-1];
                assign vld_in  = valid_reg[s-1];
            end

            assign dsh = 64'(len_in) << K;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[s] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int i = 0; i < L; i++)
                    begin
                        if ({2'b00, rem_in[i]} >= dsh)
                        begin
                            rem_reg[s][i] <= rem_in[i] - dsh[61:0];
                            q_reg[s][i]   <= {q_in[i][29:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg[s][i] <= rem_in[i];
                            q_reg[s][i]   <= {q_in[i][29:0], 1'b0};
                        end
                    end
                    ovf_reg[s]  <= ovf_in;
                    len_reg[s]  <= len_in;
                    side_reg[s] <= side_in;
                end
            end
        end
    endgenerate

    assign quot_valid = valid_reg[N-1];
    assign quot_len   = len_reg[N-1];
    assign quot_side  = side_reg[N-1];
    assign quot_ovf   = ovf_reg[N-1];
    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            quot[i] = q_reg[N-1][i];
        end
    end

endmodule

@@ hw/rtl/vector_normalizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_normalizer
// Euclidean normalization of a 2/3/4 component Q16.16 vector to Q2.30.
// Throughput: one item per cycle; a stall at the output freezes the whole pipe.
// Stages: 4 sum of squares, 32 square root, 31 divide, 1 output register.
// Reset: asynchronous active low; pipe emptied, dimension set to 3.
// ----------------------------------------------------------------------------
module vector_normalizer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                dim_we,
    input  logic [2:0]          dim_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  comp_x,
    input  logic signed [31:0]  comp_y,
    input  logic signed [31:0]  comp_z,
    input  logic signed [31:0]  comp_w,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  unit_x,
    output logic signed [31:0]  unit_y,
    output logic signed [31:0]  unit_z,
    output logic signed [31:0]  unit_w,
    output logic [32:0]         vector_length,
    output logic                was_zero
);

    logic          en;
    logic [2:0]    dim_reg;
    logic          sum_valid, len_valid, quot_valid;
    logic [64:0]   sum;
    logic [32:0]   len, quot_len;
    vn_pkg::side_t sum_side, len_side, quot_side;
    logic [30:0]   quot [vn_pkg::LanesN];
    logic [3:0]    quot_ovf;
    logic [31:0]   unit_next [vn_pkg::LanesN];
    logic [31:0]   unit_reg  [vn_pkg::LanesN];
    logic          out_valid_reg;
    logic [32:0]   len_reg;
    logic          zero_reg;

    assign en       = ~out_valid_reg | out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= vn_pkg::DimReset;
        end
        else if (dim_we)
        begin
            dim_reg <= dim_data;
        end
    end

    vn_sumsq u_sumsq (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .comp_x    (comp_x),
        .comp_y    (comp_y),
        .comp_z    (comp_z),
        .comp_w    (comp_w),
        .dim       (dim_reg),
        .sum_valid (sum_valid),
        .sum       (sum),
        .sum_side  (sum_side)
    );

    vn_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .sum_valid (sum_valid),
        .sum       (sum),
        .sum_side  (sum_side),
        .len_valid (len_valid),
        .len       (len),
        .len_side  (len_side)
    );

    vn_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .len_valid  (len_valid),
        .len        (len),
        .len_side   (len_side),
        .quot_valid (quot_valid),
        .quot_len   (quot_len),
        .quot_side  (quot_side),
        .quot       (quot),
        .quot_ovf   (quot_ovf)
    );

    always_comb
    begin
        logic [30:0] q;
        for (int i = 0; i < vn_pkg::LanesN; i++)
        begin
            q = (quot_ovf[i] || quot[i] > vn_pkg::UnitOne) ? vn_pkg::UnitOne : quot[i];
            if (quot_side.act[i] && quot_len != 33'd0)
            begin
                unit_next[i] = quot_side.neg[i] ? (32'd0 - {1'b0, q}) : {1'b0, q};
            end
            else
            begin
                unit_next[i] = 32'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= quot_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < vn_pkg::LanesN; i++)
            begin
                unit_reg[i] <= unit_next[i];
            end
            len_reg  <= quot_len;
            zero_reg <= quot_len == 33'd0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign unit_x        = unit_reg[0];
    assign unit_y        = unit_reg[1];
    assign unit_z        = unit_reg[2];
    assign unit_w        = unit_reg[3];
    assign vector_length = len_reg;
    assign was_zero      = zero_reg;

    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (was_zero == (vector_length == 33'd0)))
        else $error("was_zero disagrees with length");

    a_zero_units: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && was_zero) |-> (unit_x == 32'd0 && unit_y == 32'd0 &&
                                     unit_z == 32'd0 && unit_w == 32'd0))
        else $error("nonzero unit with zero length");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (vector_length <= vn_pkg::LenMax))
        else $error("length out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(unit_x) &&
                                       $stable(vector_length)))
        else $error("output changed during stall");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for vector_normalizer. A directed table covers the
// extremes and zero vectors. It is followed by random phases over every
// dimension setting, including out-of-range ones. Each accepted vector is
// predicted and queued, and each output item is checked against the queue.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  HalfPeriod = 6;
    localparam int  PipeDelay  = 80;
    localparam int  CycleLimit = 400000;
    localparam int  PhaseItems = 120;

    localparam logic signed [31:0] CompMin = 32'sh8000_0000;
    localparam logic signed [31:0] CompMax = 32'sh7fff_ffff;
    localparam logic signed [31:0] OneQ16  = 32'sh0001_0000;

    typedef struct packed {
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [31:0] uz;
        logic signed [31:0] uw;
        logic [32:0]        len;
        logic               zero;
    } unit_vec_t;

    typedef struct {
        logic [2:0]         dim;
        logic signed [31:0] x, y, z, w;
        bit                 known;
        unit_vec_t          res;
    } vec_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               dim_we = 1'b0;
    logic [2:0]         dim_data = 3'd0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] comp_x = '0, comp_y = '0, comp_z = '0, comp_w = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] unit_x, unit_y, unit_z, unit_w;
    logic [32:0]        vector_length;
    logic               was_zero;

    unit_vec_t   pending_units[$];
    logic [2:0]  dim_model = vn_pkg::DimReset;
    bit          idle_on = 1'b0;
    int          errors = 0;
    int          cycles = 0;
    int          stall_left = 0;

    vector_normalizer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .dim_we        (dim_we),
        .dim_data      (dim_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .comp_x        (comp_x),
        .comp_y        (comp_y),
        .comp_z        (comp_z),
        .comp_w        (comp_w),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .unit_x        (unit_x),
        .unit_y        (unit_y),
        .unit_z        (unit_z),
        .unit_w        (unit_w),
        .vector_length (vector_length),
        .was_zero      (was_zero)
    );

    always
    begin
        #HalfPeriod clk = 1'b1;
        #HalfPeriod clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic unit_vec_t normalize(logic [2:0] dim, logic signed [31:0] x,
                                            logic signed [31:0] y, logic signed [31:0] z,
                                            logic signed [31:0] w);
        logic signed [31:0] c[4];
        logic [31:0]        mag[4];
        logic [31:0]        q[4];
        logic [64:0]        sum;
        logic [64:0]        trial;
        logic [32:0]        root;
        logic [63:0]        quot;
        int                 active;
        unit_vec_t          r;
        c[0] = x; c[1] = y; c[2] = z; c[3] = w;
        active = (dim < 2) ? 2 : (dim > 4) ? 4 : dim;
        sum = '0;
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = c[i][31] ? (~c[i] + 32'd1) : c[i];
            if (i < active)
                sum = sum + 65'(mag[i]) * 65'(mag[i]);
        end
        // only four components of -2^31 carry into bit 64
        if (sum[64])
            root = vn_pkg::LenMax;
        else
        begin
            root = '0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = 65'(root | (33'd1 << b));
                if (trial * trial <= sum)
                    root = root | (33'd1 << b);
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            q[i] = '0;
            if (i < active && root != 0)
            begin
                quot = ({32'd0, mag[i]} << 30) / {31'd0, root};
                if (quot > 64'(vn_pkg::UnitOne))
                    quot = 64'(vn_pkg::UnitOne);
                q[i] = c[i][31] ? -quot[31:0] : quot[31:0];
            end
        end
        r.ux = q[0]; r.uy = q[1]; r.uz = q[2]; r.uw = q[3];
        r.len = root;
        r.zero = (root == 0);
        return r;
    endfunction

    // output side: random stall bursts and checking
    always @(posedge clk)
    begin
        unit_vec_t exp_u;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_units.size() == 0)
            begin
                $display("%0t: unexpected item, length %h", $time, vector_length);
                errors++;
            end
            else
            begin
                exp_u = pending_units.pop_front();
                if (exp_u.ux !== unit_x)
                begin
                    $display("%0t: unit_x exp %h got %h", $time, exp_u.ux, unit_x);
                    errors++;
                end
                if (exp_u.uy !== unit_y)
                begin
                    $display("%0t: unit_y exp %h got %h", $time, exp_u.uy, unit_y);
                    errors++;
                end
                if (exp_u.uz !== unit_z)
                begin
                    $display("%0t: unit_z exp %h got %h", $time, exp_u.uz, unit_z);
                    errors++;
                end
                if (exp_u.uw !== unit_w)
                begin
                    $display("%0t: unit_w exp %h got %h", $time, exp_u.uw, unit_w);
                    errors++;
                end
                if (exp_u.len !== vector_length)
                begin
                    $display("%0t: vector_length exp %h got %h", $time, exp_u.len,
                             vector_length);
                    errors++;
                end
                if (exp_u.zero !== was_zero)
                begin
                    $display("%0t: was_zero exp %b got %b", $time, exp_u.zero, was_zero);
                    errors++;
                end
            end
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0)
                stall_left <= $urandom_range(1, 9);
        end
    end

    task automatic send_vector(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, logic signed [31:0] w,
                               bit known, unit_vec_t res);
        int gap;
        in_valid <= 1'b1;
        comp_x <= x; comp_y <= y; comp_z <= z; comp_w <= w;
        do
            @(posedge clk);
        while (!in_ready);
        pending_units.push_back(known ? res : normalize(dim_model, x, y, z, w));
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (PipeDelay) @(posedge clk);
    endtask

    task automatic write_dimension(logic [2:0] value);
        dim_we <= 1'b1;
        dim_data <= value;
        @(posedge clk);
        dim_we <= 1'b0;
        dim_model = value;
    endtask

    function automatic logic signed [31:0] pick_comp();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5:       return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
            6:          return '0;
            7:          return $urandom_range(0, 1) ? CompMin : CompMax;
            8:          return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
            default:    return $signed($urandom) >>> $urandom_range(0, 31);
        endcase
    endfunction

    vec_row_t dir_rows[$];

    function automatic vec_row_t row(logic [2:0] dim, logic signed [31:0] x,
                                     logic signed [31:0] y, logic signed [31:0] z,
                                     logic signed [31:0] w, bit known,
                                     logic signed [31:0] ux, logic signed [31:0] uy,
                                     logic signed [31:0] uz, logic signed [31:0] uw,
                                     logic [32:0] len);
        vec_row_t r;
        r.dim = dim; r.x = x; r.y = y; r.z = z; r.w = w; r.known = known;
        r.res.ux = ux; r.res.uy = uy; r.res.uz = uz; r.res.uw = uw;
        r.res.len = len; r.res.zero = (len == 0);
        return r;
    endfunction

    initial
    begin
        logic [2:0] phase_dims[10];
        logic signed [31:0] a, b, c, d;
        logic signed [31:0] u1;
        u1 = 32'sh4000_0000;
        phase_dims = '{3'd2, 3'd4, 3'd0, 3'd7, 3'd1, 3'd3, 3'd5, 3'd6, 3'd2, 3'd4};

        // dimension 3 is the reset value
        dir_rows.push_back(row(3, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(3, OneQ16, 0, 0, CompMax, 1, u1, 0, 0, 0, 33'h1_0000));
        dir_rows.push_back(row(3, -OneQ16, 0, 0, 0, 1, -u1, 0, 0, 0, 33'h1_0000));
        dir_rows.push_back(row(3, 0, 0, CompMin, 0, 1, 0, 0, -u1, 0, 33'h8000_0000));
        dir_rows.push_back(row(3, CompMax, CompMax, CompMax, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(3, CompMin, CompMax, 1, -1, 0, 0, 0, 0, 0, 0));
        // inactive components are ignored, so this is a zero length
        dir_rows.push_back(row(2, 0, 0, CompMax, CompMin, 1, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(2, 1, 0, 0, 0, 1, u1, 0, 0, 0, 33'd1));
        dir_rows.push_back(row(2, 0, -1, 0, 0, 1, 0, -u1, 0, 0, 33'd1));
        dir_rows.push_back(row(2, 32'sd196608, 32'sd262144, 5, 5, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(2, CompMin, CompMin, 0, 0, 0, 0, 0, 0, 0, 0));
        // largest sum: length 2^32, each unit -2^29
        dir_rows.push_back(row(4, CompMin, CompMin, CompMin, CompMin, 1,
                               -(u1 >>> 1), -(u1 >>> 1), -(u1 >>> 1), -(u1 >>> 1),
                               vn_pkg::LenMax));
        dir_rows.push_back(row(4, 1, 1, 1, 1, 1,
                               u1 >>> 1, u1 >>> 1, u1 >>> 1, u1 >>> 1, 33'd2));
        dir_rows.push_back(row(4, CompMax, CompMax, CompMax, CompMax, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(4, 0, 0, 0, -OneQ16, 1, 0, 0, 0, -u1, 33'h1_0000));
        dir_rows.push_back(row(4, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
        // below 2 acts as 2, above 4 acts as 4
        dir_rows.push_back(row(0, OneQ16, OneQ16, CompMax, CompMax, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(1, 0, 0, OneQ16, 0, 1, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(7, 0, 0, 0, OneQ16, 1, 0, 0, 0, u1, 33'h1_0000));
        dir_rows.push_back(row(5, CompMin, 3, -7, CompMax, 0, 0, 0, 0, 0, 0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].dim != dim_model)
            begin
                drain_pipe();
                write_dimension(dir_rows[i].dim);
            end
            send_vector(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].w,
                        dir_rows[i].known, dir_rows[i].res);
        end

        for (int p = 0; p < 10; p++)
        begin
            drain_pipe();
            write_dimension(phase_dims[p]);
            for (int n = 0; n < PhaseItems; n++)
            begin
                // last phase runs without idling; elsewhere idling comes and goes
                if (n % 40 == 0)
                    idle_on = (p != 9) && ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 19) == 0)
                begin
                    a = 0; b = 0; c = pick_comp(); d = pick_comp();
                end
                else
                begin
                    a = pick_comp(); b = pick_comp(); c = pick_comp(); d = pick_comp();
                end
                send_vector(a, b, c, d, 1'b0, '0);
            end
        end

        idle_on = 1'b0;
        drain_pipe();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ vector_normalizer.f @@
hw/rtl/vn_pkg.sv
hw/rtl/vn_sumsq.sv
hw/rtl/vn_isqrt.sv
hw/rtl/vn_divider.sv
hw/rtl/vector_normalizer.sv
bench/testbench.sv
